[rtl/kdlp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants of the keypad debounce / long-press block.
// ---------------------------------------------------------------------------
package kdlp_pkg;

  localparam int NumKeysDefault   = 16;
  localparam int PinLimit         = 16;
  localparam int LevelWidth       = 16;
  localparam int TickWidth        = 16;
  localparam int CountWidth       = 5;
  localparam int IndexWidth       = 4;
  localparam int AddrWidth        = 4;
  localparam int DataWidth        = 32;

  localparam logic [TickWidth-1:0]  DebounceReset  = 16'd20;
  localparam logic [TickWidth-1:0]  LongPressReset = 16'd1000;
  localparam logic [CountWidth-1:0] KeyCountReset  = 5'd16;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2
  } ev_kind_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_KEY_COUNT  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'b001,
    MODE_DEBOUNCE = 3'b010,
    MODE_LONG     = 3'b100
  } mode_e;

  typedef struct packed {
    logic sample;
    logic tick;
    logic enable;
    logic changed;
    logic level_down;
  } lane_cmd_t;

  typedef struct packed {
    logic     hit;
    ev_kind_e kind;
  } lane_evt_t;

endpackage
`default_nettype wire

[rtl/kdlp_lane.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_lane
// Per-key debounce and long-press timer; reports at most one event per tick.
// ---------------------------------------------------------------------------
module kdlp_lane
  import kdlp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lane_cmd_t            cmd_i,
  input  wire logic [TickWidth-1:0] debounce_i,
  input  wire logic [TickWidth-1:0] long_press_i,
  output lane_evt_t                 evt_o
);

  mode_e                mode_q, mode_d;
  logic [TickWidth-1:0] ticks_q, ticks_d;
  logic                 raw_q, raw_d;
  logic                 stable_q, stable_d;

  always_comb begin
    mode_d    = mode_q;
    ticks_d   = ticks_q;
    raw_d     = raw_q;
    stable_d  = stable_q;
    evt_o.hit  = 1'b0;
    evt_o.kind = EV_PRESSED;
    if (cmd_i.enable && cmd_i.sample && cmd_i.changed) begin
      raw_d   = cmd_i.level_down;
      mode_d  = MODE_DEBOUNCE;
      ticks_d = debounce_i;
    end else if (cmd_i.enable && cmd_i.tick) begin
      unique case (mode_q)
        MODE_DEBOUNCE: begin
          if (ticks_q > 16'd1) begin
            ticks_d = ticks_q - 16'd1;
          end else begin
            evt_o.hit = 1'b1;
            if (raw_q) begin
              stable_d   = 1'b1;
              mode_d     = MODE_LONG;
              ticks_d    = long_press_i;
              evt_o.kind = EV_PRESSED;
            end else begin
              stable_d   = 1'b0;
              mode_d     = MODE_IDLE;
              ticks_d    = '0;
              evt_o.kind = EV_RELEASED;
            end
          end
        end
        MODE_LONG: begin
          if (ticks_q > 16'd1) begin
            ticks_d = ticks_q - 16'd1;
          end else begin
            // drop silently if the key is no longer held
            mode_d     = MODE_IDLE;
            ticks_d    = '0;
            evt_o.hit  = stable_q;
            evt_o.kind = EV_LONG;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      ticks_q  <= '0;
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      ticks_q  <= ticks_d;
      raw_q    <= raw_d;
      stable_q <= stable_d;
    end
  end

endmodule
`default_nettype wire

[rtl/kdlp_merge.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_merge
// Collects the lane events of one tick and emits them in ascending key order.
// ---------------------------------------------------------------------------
module kdlp_merge
  import kdlp_pkg::*;
#(
  parameter int LANES = NumKeysDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire lane_evt_t             evt_i [LANES],
  output logic                       busy_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [IndexWidth-1:0]      key_id_o,
  output logic [1:0]                 event_kind_o,
  output logic                       last_o
);

  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0] pend_q, pend_d;
  ev_kind_e         kind_q [LANES];
  logic [LANES-1:0] pick;
  logic [IW-1:0]    pick_idx;
  logic             emit;

  logic                  out_valid_q, out_valid_d;
  logic [IndexWidth-1:0] idx_q;
  ev_kind_e              okind_q;
  logic                  last_q;

  // lowest pending lane wins
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int n = LANES - 1; n >= 0; n--) begin
      if (pend_q[n]) begin
        pick     = '0;
        pick[n]  = 1'b1;
        pick_idx = IW'(n);
      end
    end
  end

  assign emit   = (|pend_q) && (!out_valid_q || !out_stall_i);
  assign busy_o = |pend_q;

  always_comb begin
    pend_d = pend_q;
    if (load_i) begin
      for (int n = 0; n < LANES; n++) begin
        pend_d[n] = evt_i[n].hit;
      end
    end else if (emit) begin
      pend_d = pend_q & ~pick;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int n = 0; n < LANES; n++) begin
        kind_q[n] <= evt_i[n].kind;
      end
    end
    if (emit) begin
      idx_q   <= IndexWidth'(pick_idx);
      okind_q <= kind_q[pick_idx];
      last_q  <= ((pend_q & ~pick) == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_id_o     = idx_q;
  assign event_kind_o = okind_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

[rtl/keypad_debounce_long_press_core.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// keypad_debounce_long_press_core
// Debounce of active-low keys with long-press detection, one lane per key.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  input    | in_valid_i / in_stall_o   | operation_i, key_levels_i
//  output   | out_valid_o / out_stall_i | key_id_o, event_kind_o, last_o
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A sample or a tick updates all enabled key lanes together.
// The events of a tick leave the merge stage one per cycle unless the output
// stalls, so a tick with E events holds the input until all E have left.
// Output stalls hold the merge stage; the input stays stalled until it drains.
// Reset puts every key idle and released, all previous levels high.
module keypad_debounce_long_press_core
  import kdlp_pkg::*;
#(
  parameter int NUM_KEYS = NumKeysDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  operation_i,
  input  wire logic [LevelWidth-1:0] key_levels_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [IndexWidth-1:0]      key_id_o,
  output logic [1:0]                 event_kind_o,
  output logic                       last_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [AddrWidth-1:0]  paddr,
  input  wire logic [DataWidth-1:0]  pwdata,
  output logic [DataWidth-1:0]       prdata,
  output logic                       pready
);

  localparam int LANES = (NUM_KEYS < PinLimit) ? NUM_KEYS : PinLimit;

  logic [TickWidth-1:0]  debounce_q, long_press_q;
  logic [CountWidth-1:0] key_count_q;
  logic [LevelWidth-1:0] prev_q;
  logic                  cfg_wr, in_fire, busy;
  reg_idx_e              reg_idx;
  lane_evt_t             evt [LANES];

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE:   prdata = DataWidth'(debounce_q);
      REG_LONG_PRESS: prdata = DataWidth'(long_press_q);
      REG_KEY_COUNT:  prdata = DataWidth'(key_count_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
      key_count_q  <= KeyCountReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEBOUNCE:   debounce_q   <= pwdata[TickWidth-1:0];
        REG_LONG_PRESS: long_press_q <= pwdata[TickWidth-1:0];
        REG_KEY_COUNT:  key_count_q  <= pwdata[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '1;
    end else if (in_fire && (op_e'(operation_i) == OP_SAMPLE)) begin
      prev_q <= key_levels_i;
    end
  end

  for (genvar n = 0; n < LANES; n++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.sample     = in_fire && (op_e'(operation_i) == OP_SAMPLE);
    assign cmd.tick       = in_fire && (op_e'(operation_i) == OP_TICK);
    assign cmd.enable     = key_count_q > CountWidth'(n);
    assign cmd.changed    = prev_q[n] ^ key_levels_i[n];
    assign cmd.level_down = !key_levels_i[n];

    kdlp_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .debounce_i   (debounce_q),
      .long_press_i (long_press_q),
      .evt_o        (evt[n])
    );
  end

  kdlp_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_fire && (op_e'(operation_i) == OP_TICK)),
    .evt_i        (evt),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_id_o     (key_id_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

[bench/kdlp_event_check.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// kdlp_event_check
// Watches the input, output and register ports of the keypad core, keeps
// its own copy of every key lane, predicts the events each tick causes and
// compares every output beat against the oldest predicted event.
// ---------------------------------------------------------------------------
module kdlp_event_check
  import kdlp_pkg::*;
#(
  parameter int NUM_KEYS = NumKeysDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_o,
  input  wire logic                  operation_i,
  input  wire logic [LevelWidth-1:0] key_levels_i,
  input  wire logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  input  wire logic [IndexWidth-1:0] key_id_o,
  input  wire logic [1:0]            event_kind_o,
  input  wire logic                  last_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [AddrWidth-1:0]  paddr,
  input  wire logic [DataWidth-1:0]  pwdata,
  input  wire logic                  pready,
  output int                         error_total,
  output int                         events_outstanding
);

  typedef struct packed {
    logic [IndexWidth-1:0] key;
    ev_kind_e              kind;
    logic                  last;
  } key_event_t;

  key_event_t pending_events[$];
  int errors;

  logic [TickWidth-1:0]  debounce_cfg;
  logic [TickWidth-1:0]  long_press_cfg;
  logic [CountWidth-1:0] key_count_cfg;

  logic [LevelWidth-1:0] last_levels;
  mode_e                 lane_mode     [NUM_KEYS];
  logic [TickWidth-1:0]  lane_ticks    [NUM_KEYS];
  logic                  lane_raw_down [NUM_KEYS];
  logic                  lane_held     [NUM_KEYS];

  function automatic int keys_in_use();
    int n;
    n = int'(key_count_cfg);
    if (n > NUM_KEYS) n = NUM_KEYS;
    if (n > PinLimit) n = PinLimit;
    return n;
  endfunction

  // Changed pins of keys in use restart debounce; a running long press is lost.
  task automatic apply_sample(input logic [LevelWidth-1:0] levels);
    logic [LevelWidth-1:0] changed;
    changed = last_levels ^ levels;
    for (int k = 0; k < keys_in_use(); k++) begin
      if (changed[k]) begin
        lane_raw_down[k] = ~levels[k];
        lane_mode[k]     = MODE_DEBOUNCE;
        lane_ticks[k]    = debounce_cfg;
      end
    end
    last_levels = levels;
  endtask

  task automatic apply_tick();
    key_event_t evs[$];
    key_event_t ev;
    bit         fire;
    for (int k = 0; k < keys_in_use(); k++) begin
      if (lane_mode[k] != MODE_DEBOUNCE && lane_mode[k] != MODE_LONG) continue;
      if (lane_ticks[k] > 1) begin
        lane_ticks[k] = lane_ticks[k] - 1'b1;
        continue;
      end
      lane_ticks[k] = '0;
      fire = 1'b1;
      if (lane_mode[k] == MODE_DEBOUNCE) begin
        if (lane_raw_down[k]) begin
          lane_held[k]  = 1'b1;
          lane_mode[k]  = MODE_LONG;
          lane_ticks[k] = long_press_cfg;
          ev.kind       = EV_PRESSED;
        end else begin
          lane_held[k] = 1'b0;
          lane_mode[k] = MODE_IDLE;
          ev.kind      = EV_RELEASED;
        end
      end else begin
        lane_mode[k] = MODE_IDLE;
        if (!lane_held[k]) fire = 1'b0;
        ev.kind = EV_LONG;
      end
      if (fire) begin
        ev.key  = IndexWidth'(k);
        ev.last = 1'b0;
        evs.push_back(ev);
      end
    end
    foreach (evs[j]) begin
      ev      = evs[j];
      ev.last = (j == evs.size() - 1);
      pending_events.push_back(ev);
    end
  endtask

  task automatic check_beat();
    key_event_t ev;
    if (pending_events.size() == 0) begin
      errors++;
      $display("%0t: unexpected event, expected none, actual key %0d kind %0d last %0d",
               $time, key_id_o, event_kind_o, last_o);
    end else begin
      ev = pending_events.pop_front();
      if (key_id_o !== ev.key) begin
        errors++;
        $display("%0t: key_id expected %0d actual %0d", $time, ev.key, key_id_o);
      end
      if (event_kind_o !== ev.kind) begin
        errors++;
        $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, event_kind_o);
      end
      if (last_o !== ev.last) begin
        errors++;
        $display("%0t: last expected %0d actual %0d", $time, ev.last, last_o);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_cfg   = DebounceReset;
      long_press_cfg = LongPressReset;
      key_count_cfg  = KeyCountReset;
      last_levels    = '1;
      for (int k = 0; k < NUM_KEYS; k++) begin
        lane_mode[k]     = MODE_IDLE;
        lane_ticks[k]    = '0;
        lane_raw_down[k] = 1'b0;
        lane_held[k]     = 1'b0;
      end
      pending_events.delete();
      errors = 0;
    end else begin
      // Retire the older beat first: an output here never belongs to this input.
      if (out_valid_o && !out_stall_i) check_beat();
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_DEBOUNCE:   debounce_cfg   = pwdata[TickWidth-1:0];
          REG_LONG_PRESS: long_press_cfg = pwdata[TickWidth-1:0];
          REG_KEY_COUNT:  key_count_cfg  = pwdata[CountWidth-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (op_e'(operation_i) == OP_TICK) apply_tick();
        else apply_sample(key_levels_i);
      end
    end
    error_total        <= errors;
    events_outstanding <= pending_events.size();
  end

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top
// Drives samples and ticks into the keypad debounce core under several
// register settings, with random idle bursts on the input and stall bursts
// on the output; the event checker beside the core predicts and compares every event.
// ---------------------------------------------------------------------------
module tb_top;
  import kdlp_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [LevelWidth-1:0] key_levels_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [IndexWidth-1:0] key_id_o;
  logic [1:0]            event_kind_o;
  logic                  last_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrWidth-1:0]  paddr;
  logic [DataWidth-1:0]  pwdata;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;

  int error_total;
  int events_outstanding;

  bit                    idling;
  logic [LevelWidth-1:0] pins;

  keypad_debounce_long_press_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_id_o     (key_id_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  kdlp_event_check u_event_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .key_levels_i       (key_levels_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .key_id_o           (key_id_o),
    .event_kind_o       (event_kind_o),
    .last_o             (last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .error_total        (error_total),
    .events_outstanding (events_outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Random output stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hold valid high until the beat is taken; valid stays up between beats unless an idle gap is inserted.
  task automatic send_beat(input op_e op, input logic [LevelWidth-1:0] levels);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    key_levels_i <= levels;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic tick();
    send_beat(OP_TICK, LevelWidth'($urandom()));
  endtask

  task automatic sample_pins(input logic [LevelWidth-1:0] levels);
    pins = levels;
    send_beat(OP_SAMPLE, pins);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop sending and wait until every predicted event has left the core.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (events_outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic configure(input int debounce, input int long_press, input int keys);
    drain();
    reg_write(REG_DEBOUNCE, DataWidth'(debounce));
    reg_write(REG_LONG_PRESS, DataWidth'(long_press));
    reg_write(REG_KEY_COUNT, DataWidth'(keys));
  endtask

  // Mostly ticks and single-key changes, so keys settle and events follow;
  // full random words and quick bounces mixed in as noise.
  task automatic random_item();
    int pick;
    logic [LevelWidth-1:0] flip;
    pick = $urandom_range(0, 99);
    flip = LevelWidth'(1) << $urandom_range(0, LevelWidth - 1);
    if (pick < 65) begin
      tick();
    end else if (pick < 85) begin
      sample_pins(pins ^ flip);
    end else if (pick < 93) begin
      sample_pins(LevelWidth'($urandom()));
    end else begin
      sample_pins(pins ^ flip);
      sample_pins(pins ^ flip);
    end
  endtask

  task automatic run_phase(input int debounce, input int long_press, input int keys,
                           input int items, input bit with_idle);
    configure(debounce, long_press, keys);
    idling = with_idle;
    repeat (items) random_item();
  endtask

  initial begin
    idling = 1'b1;
    pins   = '1;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OP_SAMPLE;
    key_levels_i <= '1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all keys at once, long press, bounce, cancel of a long press.
    configure(1, 2, 16);
    sample_pins(16'h0000);
    tick();
    tick();
    tick();
    sample_pins(16'hFFFF);
    tick();
    sample_pins(16'hFFFE);
    sample_pins(16'hFFFF);
    tick();
    sample_pins(16'h7FFF);
    tick();
    sample_pins(16'hFFFF);
    tick();
    tick();
    sample_pins(16'hAAAA);
    tick();
    sample_pins(16'h5555);
    tick();
    tick();

    run_phase(1, 1, 16, 60, 1'b1);
    run_phase(3, 5, 16, 70, 1'b1);
    run_phase(2, 4, 1, 50, 1'b1);
    run_phase(65535, 65535, 16, 15, 1'b1);
    run_phase(2, 3, 9, 60, 1'b1);
    run_phase(4, 8, 16, 70, 1'b1);
    run_phase(1, 2, 16, 100, 1'b0);

    drain();
    if (error_total == 0 && events_outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/kdlp_pkg.sv
rtl/kdlp_lane.sv
rtl/kdlp_merge.sv
rtl/keypad_debounce_long_press_core.sv
bench/kdlp_event_check.sv
bench/tb_top.sv
